// ===== rtl/pdm_pkg.sv =====
// Shared types, codes and modular helpers for the polynomial divider mod n.
// Used by the channel interfaces, controller, datapath and arithmetic units.
`default_nettype none

package pdm_pkg;

  // Payload widths
  localparam int COEFF_W = 32;
  localparam int IDX_W   = 8;
  localparam int LEN_W   = 9;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_LOAD_DIV = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_DVD = 2'd1;
  localparam logic [OP_W-1:0] OP_READ     = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_NOINV = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // Datapath commands issued by the controller
  typedef logic [4:0] cmd_t;
  localparam cmd_t CMD_NONE         = 5'd0;
  localparam cmd_t CMD_CAPTURE      = 5'd1;
  localparam cmd_t CMD_XRED_START   = 5'd2;
  localparam cmd_t CMD_XRED_TAKE    = 5'd3;
  localparam cmd_t CMD_STORE        = 5'd4;
  localparam cmd_t CMD_RESP         = 5'd5;
  localparam cmd_t CMD_READ_TAKE    = 5'd6;
  localparam cmd_t CMD_DV_BEGIN     = 5'd7;
  localparam cmd_t CMD_LEAD_TAKE    = 5'd8;
  localparam cmd_t CMD_INV_INIT     = 5'd9;
  localparam cmd_t CMD_EU_DIV_START = 5'd10;
  localparam cmd_t CMD_EU_DIV_TAKE  = 5'd11;
  localparam cmd_t CMD_EU_MUL_START = 5'd12;
  localparam cmd_t CMD_EU_MUL_TAKE  = 5'd13;
  localparam cmd_t CMD_EU_END       = 5'd14;
  localparam cmd_t CMD_DV_SETUP     = 5'd15;
  localparam cmd_t CMD_K_TAKE       = 5'd16;
  localparam cmd_t CMD_Q_ZERO       = 5'd17;
  localparam cmd_t CMD_Q_MUL_START  = 5'd18;
  localparam cmd_t CMD_Q_MUL_TAKE   = 5'd19;
  localparam cmd_t CMD_K_WRITE      = 5'd20;
  localparam cmd_t CMD_J_TAKE       = 5'd21;
  localparam cmd_t CMD_S_MUL_START  = 5'd22;
  localparam cmd_t CMD_J_UPD        = 5'd23;
  localparam cmd_t CMD_K_DEC        = 5'd24;
  localparam cmd_t CMD_DV_FIN       = 5'd25;

  // Datapath status seen by the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            last;
    logic            x_ge_n;
    logic            x_zero;
    logic            dcount_zero;
    logic            r1_zero;
    logic            r0_one;
    logic            short_dvd;
    logic            j_run;
    logic            k_zero;
    logic            div_done;
    logic            mul_done;
    logic            out_free;
  } dp_status_t;

  // x + y mod n, both operands below n
  function automatic logic [COEFF_W-1:0] add_m(input logic [COEFF_W-1:0] x,
                                               input logic [COEFF_W-1:0] y,
                                               input logic [COEFF_W-1:0] n);
    logic [COEFF_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[COEFF_W-1:0];
  endfunction

  // x - y mod n, both operands below n
  function automatic logic [COEFF_W-1:0] sub_m(input logic [COEFF_W-1:0] x,
                                               input logic [COEFF_W-1:0] y,
                                               input logic [COEFF_W-1:0] n);
    logic [COEFF_W-1:0] r;
    if (x >= y) begin
      r = x - y;
    end else begin
      r = x + (n - y);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pdm_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on pdm_pkg for payload widths.
`default_nettype none

interface pdm_item_if import pdm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [COEFF_W-1:0] coeff_value;
  logic              last_item;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, opcode, coeff_value, last_item, read_index, input ready);
  modport sink   (input valid, opcode, coeff_value, last_item, read_index, output ready);
endinterface

interface pdm_result_if import pdm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COEFF_W-1:0] quotient_coeff;
  logic [LEN_W-1:0]   quotient_length;
  logic [ST_W-1:0]    status;

  modport source (output valid, quotient_coeff, quotient_length, status, input ready);
  modport sink   (input valid, quotient_coeff, quotient_length, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/poly_div_mod_n.sv =====
// Polynomial long division modulo n, quotient only.
// Channels: item (sink) takes requests: load divisor coefficient, load
// dividend coefficient (lowest degree first, last_item closes the
// polynomial), or read a quotient coefficient by degree. result (source)
// returns exactly one response per request: coefficient, quotient length,
// status. The modulus is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while idle, as the block does not enforce this.
// Requests are handled one at a time; a load coefficient at or above the
// modulus is first reduced by the 32-step divider. The closing dividend
// load runs the division: an extended Euclid inverse of the leading divisor
// coefficient (each round a divide and a bit-serial multiply), then for each
// quotient coefficient a multiply of the remainder coefficient by that inverse
// and, if the result is non-zero, a multiply-subtract per lower divisor term.
// Reset (synchronous, active high) empties both polynomials and the
// quotient, sets the modulus to 2 and the status to ok. Memory contents are
// not cleared and need no clearing pass. A stalled receiver holds the
// response in the output register; the next request is taken meanwhile and
// waits for that register to free before its own response is loaded.
`default_nettype none

module poly_div_mod_n import pdm_pkg::*; #(
  parameter int MAX_LEN = 256
) (
  input  logic               clk,
  input  logic               rst,
  pdm_item_if.sink           item,
  pdm_result_if.source       result,
  input  logic               cfg_wr_en,
  input  logic [COEFF_W-1:0] cfg_wr_data
);

  cmd_t       cmd;
  dp_status_t st;

  pdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .st       (st),
    .cmd      (cmd)
  );

  pdm_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_opcode   (item.opcode),
    .in_coeff    (item.coeff_value),
    .in_last     (item.last_item),
    .in_index    (item.read_index),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_coeff   (result.quotient_coeff),
    .out_length  (result.quotient_length),
    .out_status  (result.status)
  );

endmodule

`default_nettype wire

// ===== rtl/pdm_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on pdm_pkg for the coefficient width.
`default_nettype none

module pdm_divider import pdm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COEFF_W-1:0] dividend,
  input  logic [COEFF_W-1:0] divisor,
  output logic               done,
  output logic [COEFF_W-1:0] quo,
  output logic [COEFF_W-1:0] rem
);

  localparam int CNT_W = $clog2(COEFF_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(COEFF_W - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [COEFF_W-1:0] dvsr;
  logic [COEFF_W:0]   rem_sh;
  logic               ge;

  // Trial subtract of the shifted partial remainder
  assign rem_sh = {rem, quo[COEFF_W-1]};
  assign ge     = rem_sh >= {1'b0, dvsr};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= ge ? COEFF_W'(rem_sh - {1'b0, dvsr}) : rem_sh[COEFF_W-1:0];
      quo <= {quo[COEFF_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pdm_mulmod.sv =====
// Bit-serial modular multiplier: add and double, one multiplier bit per cycle.
// Depends on pdm_pkg for add_m and the coefficient width.
`default_nettype none

module pdm_mulmod import pdm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COEFF_W-1:0] op_a,
  input  logic [COEFF_W-1:0] op_b,
  input  logic [COEFF_W-1:0] n,
  output logic               done,
  output logic [COEFF_W-1:0] prod
);

  logic               busy;
  logic [COEFF_W-1:0] a;
  logic [COEFF_W-1:0] b;

  // Control: finish once the multiplier runs out of set bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && b == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Accumulate and double
  always_ff @(posedge clk) begin
    if (start) begin
      a    <= op_a;
      b    <= op_b;
      prod <= '0;
    end else if (busy && b != '0) begin
      if (b[0]) begin
        prod <= add_m(prod, a, n);
      end
      a <= add_m(a, a, n);
      b <= b >> 1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pdm_ctrl.sv =====
// Sequencer for loads, reads and the division; drives datapath commands.
// Depends on pdm_pkg for command codes and the status struct.
`default_nettype none

module pdm_ctrl import pdm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output cmd_t       cmd
);

  localparam logic [4:0] S_IDLE         = 5'd0;
  localparam logic [4:0] S_DISPATCH     = 5'd1;
  localparam logic [4:0] S_RED_CHK      = 5'd2;
  localparam logic [4:0] S_RED_WAIT     = 5'd3;
  localparam logic [4:0] S_STORE        = 5'd4;
  localparam logic [4:0] S_RESP         = 5'd5;
  localparam logic [4:0] S_READ         = 5'd6;
  localparam logic [4:0] S_READ_TAKE    = 5'd7;
  localparam logic [4:0] S_DV_BEGIN     = 5'd8;
  localparam logic [4:0] S_DV_LEAD      = 5'd9;
  localparam logic [4:0] S_INV_INIT     = 5'd10;
  localparam logic [4:0] S_EU_CHK       = 5'd11;
  localparam logic [4:0] S_EU_DIV       = 5'd12;
  localparam logic [4:0] S_EU_MUL_START = 5'd13;
  localparam logic [4:0] S_EU_MUL       = 5'd14;
  localparam logic [4:0] S_EU_END       = 5'd15;
  localparam logic [4:0] S_DV_SETUP     = 5'd16;
  localparam logic [4:0] S_K_READ       = 5'd17;
  localparam logic [4:0] S_K_TAKE       = 5'd18;
  localparam logic [4:0] S_K_Q          = 5'd19;
  localparam logic [4:0] S_K_MUL        = 5'd20;
  localparam logic [4:0] S_K_WRITE      = 5'd21;
  localparam logic [4:0] S_J_CHK        = 5'd22;
  localparam logic [4:0] S_J_READ       = 5'd23;
  localparam logic [4:0] S_J_TAKE       = 5'd24;
  localparam logic [4:0] S_J_MUL        = 5'd25;
  localparam logic [4:0] S_J_MULW       = 5'd26;
  localparam logic [4:0] S_K_NEXT       = 5'd27;
  localparam logic [4:0] S_DV_FIN       = 5'd28;

  logic [4:0] state, state_next;
  logic [4:0] ret, ret_next;

  assign in_ready = (state == S_IDLE);

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // Advance the sequence
  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.op == OP_LOAD_DIV || st.op == OP_LOAD_DVD) begin
          state_next = S_RED_CHK;
          ret_next   = S_STORE;
        end else if (st.op == OP_READ) begin
          state_next = S_READ;
        end else begin
          state_next = S_RESP;
        end
      end
      S_RED_CHK: begin
        if (st.x_ge_n) begin
          cmd        = CMD_XRED_START;
          state_next = S_RED_WAIT;
        end else begin
          state_next = ret;
        end
      end
      S_RED_WAIT: begin
        if (st.div_done) begin
          cmd        = CMD_XRED_TAKE;
          state_next = ret;
        end
      end
      S_STORE: begin
        cmd        = CMD_STORE;
        state_next = (st.op == OP_LOAD_DVD && st.last) ? S_DV_BEGIN : S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd        = CMD_RESP;
          state_next = S_IDLE;
        end
      end
      S_READ: state_next = S_READ_TAKE;
      S_READ_TAKE: begin
        cmd        = CMD_READ_TAKE;
        state_next = S_RESP;
      end
      S_DV_BEGIN: begin
        cmd        = CMD_DV_BEGIN;
        state_next = st.dcount_zero ? S_RESP : S_DV_LEAD;
      end
      S_DV_LEAD: begin
        cmd        = CMD_LEAD_TAKE;
        state_next = S_RED_CHK;
        ret_next   = S_INV_INIT;
      end
      S_INV_INIT: begin
        cmd        = CMD_INV_INIT;
        state_next = S_EU_CHK;
      end
      S_EU_CHK: begin
        if (st.r1_zero) begin
          state_next = S_EU_END;
        end else begin
          cmd        = CMD_EU_DIV_START;
          state_next = S_EU_DIV;
        end
      end
      S_EU_DIV: begin
        if (st.div_done) begin
          cmd        = CMD_EU_DIV_TAKE;
          state_next = S_EU_MUL_START;
        end
      end
      S_EU_MUL_START: begin
        cmd        = CMD_EU_MUL_START;
        state_next = S_EU_MUL;
      end
      S_EU_MUL: begin
        if (st.mul_done) begin
          cmd        = CMD_EU_MUL_TAKE;
          state_next = S_EU_CHK;
        end
      end
      S_EU_END: begin
        cmd        = CMD_EU_END;
        state_next = (!st.r0_one || st.short_dvd) ? S_RESP : S_DV_SETUP;
      end
      S_DV_SETUP: begin
        cmd        = CMD_DV_SETUP;
        state_next = S_K_READ;
      end
      S_K_READ: state_next = S_K_TAKE;
      S_K_TAKE: begin
        cmd        = CMD_K_TAKE;
        state_next = S_RED_CHK;
        ret_next   = S_K_Q;
      end
      S_K_Q: begin
        if (st.x_zero) begin
          cmd        = CMD_Q_ZERO;
          state_next = S_K_WRITE;
        end else begin
          cmd        = CMD_Q_MUL_START;
          state_next = S_K_MUL;
        end
      end
      S_K_MUL: begin
        if (st.mul_done) begin
          cmd        = CMD_Q_MUL_TAKE;
          state_next = S_K_WRITE;
        end
      end
      S_K_WRITE: begin
        cmd        = CMD_K_WRITE;
        state_next = S_J_CHK;
      end
      S_J_CHK: state_next = st.j_run ? S_J_READ : S_K_NEXT;
      S_J_READ: state_next = S_J_TAKE;
      S_J_TAKE: begin
        cmd        = CMD_J_TAKE;
        state_next = S_RED_CHK;
        ret_next   = S_J_MUL;
      end
      S_J_MUL: begin
        cmd        = CMD_S_MUL_START;
        state_next = S_J_MULW;
      end
      S_J_MULW: begin
        if (st.mul_done) begin
          cmd        = CMD_J_UPD;
          state_next = S_J_CHK;
        end
      end
      S_K_NEXT: begin
        if (st.k_zero) begin
          state_next = S_DV_FIN;
        end else begin
          cmd        = CMD_K_DEC;
          state_next = S_K_READ;
        end
      end
      S_DV_FIN: begin
        cmd        = CMD_DV_FIN;
        state_next = S_RESP;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pdm_dpath.sv =====
// Datapath: coefficient memories, Euclid and division registers, result register.
// Depends on pdm_pkg, pdm_divider and pdm_mulmod.
`default_nettype none

module pdm_dpath import pdm_pkg::*; #(
  parameter int MAX_LEN = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output dp_status_t         st,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [COEFF_W-1:0] in_coeff,
  input  logic               in_last,
  input  logic [IDX_W-1:0]   in_index,
  input  logic               cfg_wr_en,
  input  logic [COEFF_W-1:0] cfg_wr_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COEFF_W-1:0] out_coeff,
  output logic [LEN_W-1:0]   out_length,
  output logic [ST_W-1:0]    out_status
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_LEN);

  // Memories
  logic [COEFF_W-1:0] dmem [MAX_LEN];
  logic [COEFF_W-1:0] rmem [MAX_LEN];
  logic [COEFF_W-1:0] qmem [MAX_LEN];
  logic [COEFF_W-1:0] dmem_rd, rmem_rd, qmem_rd;

  // Registers
  logic [COEFF_W-1:0] modulus, neff;
  logic [OP_W-1:0]    op_r;
  logic               last_r;
  logic [IDX_W-1:0]   idx_r;
  logic [COEFF_W-1:0] x, y, qv, r0, r1, t0, t1, lead_recip;
  logic [CW-1:0]      k, j, qtrim, dcount, vcount, qcount;
  logic               found, div_closed, dvd_closed;
  logic [ST_W-1:0]    last_status, res_st;
  logic [COEFF_W-1:0] res_qc;

  // Derived values
  logic [CW-1:0]      dm1, len, base_d, base_v;
  logic [AW-1:0]      raddr_d, raddr_r;
  logic               in_range;

  // Unit hookups
  logic               div_start, div_done, mul_start, mul_done;
  logic [COEFF_W-1:0] div_a, div_b, div_quo, div_rem, mul_a, mul_b, mul_prod;

  assign neff     = (modulus < COEFF_W'(2)) ? COEFF_W'(2) : modulus;
  assign dm1      = dcount - CW'(1);
  assign len      = (dm1 < k) ? dm1 : k;
  assign base_d   = div_closed ? '0 : dcount;
  assign base_v   = dvd_closed ? '0 : vcount;
  assign raddr_d  = AW'(dm1 - j);
  assign raddr_r  = AW'(k + dm1 - j);
  assign in_range = (32'(idx_r) < 32'(qcount)) && (32'(idx_r) < MAX_LEN);

  // Shared divider: load reduction and Euclid steps
  assign div_start = (cmd == CMD_XRED_START) || (cmd == CMD_EU_DIV_START);
  assign div_a     = (cmd == CMD_EU_DIV_START) ? r0 : x;
  assign div_b     = (cmd == CMD_EU_DIV_START) ? r1 : neff;

  pdm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Shared modular multiplier
  assign mul_start = (cmd == CMD_EU_MUL_START) || (cmd == CMD_Q_MUL_START) ||
                     (cmd == CMD_S_MUL_START);
  always_comb begin
    unique case (cmd)
      CMD_EU_MUL_START: begin
        mul_a = qv;
        mul_b = t1;
      end
      CMD_Q_MUL_START: begin
        mul_a = x;
        mul_b = lead_recip;
      end
      default: begin
        mul_a = qv;
        mul_b = x;
      end
    endcase
  end

  pdm_mulmod u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .n     (neff),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Memory ports: registered reads every cycle, writes on command
  always_ff @(posedge clk) begin
    dmem_rd <= dmem[raddr_d];
    rmem_rd <= rmem[raddr_r];
    qmem_rd <= qmem[AW'(idx_r)];
    if (cmd == CMD_STORE && op_r == OP_LOAD_DIV && base_d < MAX_C) begin
      dmem[AW'(base_d)] <= x;
    end
    if (cmd == CMD_STORE && op_r == OP_LOAD_DVD && base_v < MAX_C) begin
      rmem[AW'(base_v)] <= x;
    end else if (cmd == CMD_J_UPD) begin
      rmem[raddr_r] <= sub_m(y, mul_prod, neff);
    end
    if (cmd == CMD_K_WRITE) begin
      qmem[AW'(k)] <= qv;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= COEFF_W'(2);
      dcount      <= '0;
      vcount      <= '0;
      qcount      <= '0;
      lead_recip  <= '0;
      div_closed  <= 1'b0;
      dvd_closed  <= 1'b0;
      last_status <= ST_OK;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        modulus <= cfg_wr_data;
      end
      if (cmd == CMD_STORE && op_r == OP_LOAD_DIV) begin
        dcount     <= (base_d < MAX_C) ? base_d + CW'(1) : base_d;
        div_closed <= last_r;
      end
      if (cmd == CMD_STORE && op_r == OP_LOAD_DVD) begin
        vcount     <= (base_v < MAX_C) ? base_v + CW'(1) : base_v;
        dvd_closed <= last_r;
      end
      if (cmd == CMD_DV_BEGIN) begin
        qcount <= '0;
        if (dcount == '0) begin
          last_status <= ST_EMPTY;
        end
      end
      if (cmd == CMD_EU_END) begin
        if (r0 == COEFF_W'(1)) begin
          lead_recip  <= t0;
          last_status <= ST_OK;
        end else begin
          lead_recip  <= '0;
          last_status <= ST_NOINV;
        end
      end
      if (cmd == CMD_DV_FIN) begin
        qcount <= qtrim;
      end
      // Result register: load on response, drop once taken
      if (cmd == CMD_RESP) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_CAPTURE: begin
        op_r   <= in_opcode;
        x      <= in_coeff;
        last_r <= in_last;
        idx_r  <= in_index;
        j      <= '0;
        res_qc <= '0;
        res_st <= last_status;
      end
      CMD_XRED_TAKE: x <= div_rem;
      CMD_READ_TAKE: begin
        res_qc <= in_range ? qmem_rd : '0;
        res_st <= in_range ? ST_OK : ST_RANGE;
      end
      CMD_DV_BEGIN: begin
        if (dcount == '0) begin
          res_st <= ST_EMPTY;
        end
      end
      CMD_LEAD_TAKE: x <= dmem_rd;
      CMD_INV_INIT: begin
        r0 <= neff;
        r1 <= x;
        t0 <= '0;
        t1 <= COEFF_W'(1);
      end
      CMD_EU_DIV_TAKE: begin
        qv <= (div_quo == neff) ? '0 : div_quo;
        r0 <= r1;
        r1 <= div_rem;
      end
      CMD_EU_MUL_TAKE: begin
        t0 <= t1;
        t1 <= sub_m(t0, mul_prod, neff);
      end
      CMD_EU_END: res_st <= (r0 == COEFF_W'(1)) ? ST_OK : ST_NOINV;
      CMD_DV_SETUP: begin
        k     <= vcount - dcount;
        found <= 1'b0;
        qtrim <= '0;
      end
      CMD_K_TAKE: x <= rmem_rd;
      CMD_Q_ZERO: qv <= '0;
      CMD_Q_MUL_TAKE: qv <= mul_prod;
      CMD_K_WRITE: begin
        j <= CW'(1);
        if (qv != '0 && !found) begin
          found <= 1'b1;
          qtrim <= k + CW'(1);
        end
      end
      CMD_J_TAKE: begin
        x <= dmem_rd;
        y <= rmem_rd;
      end
      CMD_J_UPD: j <= j + CW'(1);
      CMD_K_DEC: begin
        k <= k - CW'(1);
        j <= '0;
      end
      CMD_DV_FIN: res_st <= last_status;
      default: ;
    endcase
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd == CMD_RESP) begin
      out_coeff  <= res_qc;
      out_length <= LEN_W'(qcount);
      out_status <= res_st;
    end
  end

  // Status to the controller
  always_comb begin
    st.op          = op_r;
    st.last        = last_r;
    st.x_ge_n      = x >= neff;
    st.x_zero      = x == '0;
    st.dcount_zero = dcount == '0;
    st.r1_zero     = r1 == '0;
    st.r0_one      = r0 == COEFF_W'(1);
    st.short_dvd   = vcount < dcount;
    st.j_run       = (qv != '0) && (j <= len);
    st.k_zero      = k == '0;
    st.div_done    = div_done;
    st.mul_done    = mul_done;
    st.out_free    = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== bench/poly_div_mod_n_tb.sv =====
// Self-checking bench for poly_div_mod_n: polynomial long division mod n.
// Depends on pdm_pkg and the pdm_item_if / pdm_result_if channel interfaces.
`timescale 1ns / 100ps
`default_nettype none

module poly_div_mod_n_tb;
  import pdm_pkg::*;

  localparam int LEN_MAX   = 256;
  localparam int CYCLE_CAP = 4000000;
  localparam int DRAIN     = 60;

  // Opcode with no defined operation
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [COEFF_W-1:0] coeff;
    logic [LEN_W-1:0]   qlen;
    logic [ST_W-1:0]    st;
  } answer_t;

  // Quotient predictor plus store of pending answers
  class quotient_board;
    longint unsigned modulus;
    longint unsigned dvs[LEN_MAX];
    longint unsigned rem[LEN_MAX];
    longint unsigned quo[LEN_MAX];
    int unsigned     dvs_cnt, dvd_cnt, quo_cnt;
    bit              dvs_closed, dvd_closed;
    logic [ST_W-1:0] last_st;
    answer_t         pending[$];
    int              fails;

    function new();
      modulus = 2; dvs_cnt = 0; dvd_cnt = 0; quo_cnt = 0;
      dvs_closed = 0; dvd_closed = 0; last_st = ST_OK; fails = 0;
    endfunction

    function longint unsigned ring();
      return (modulus < 2) ? 64'd2 : modulus;
    endfunction

    function longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                     longint unsigned n);
      return ((a % n) * (b % n)) % n;
    endfunction

    function bit invert(longint unsigned a, longint unsigned n,
                        output longint unsigned inv);
      longint r0, r1, t0, t1, q, tmp;
      r0 = n; r1 = a % n; t0 = 0; t1 = 1;
      while (r1 != 0) begin
        q = r0 / r1;
        tmp = r0 - q * r1; r0 = r1; r1 = tmp;
        tmp = t0 - q * t1; t0 = t1; t1 = tmp;
      end
      inv = (t0 < 0) ? t0 + n : t0;
      return r0 == 1;
    endfunction

    function void divide();
      longint unsigned n, linv, r, q, y;
      int unsigned qlen, len, ri;
      n = ring();
      quo_cnt = 0;
      if (dvs_cnt == 0) begin
        last_st = ST_EMPTY;
        return;
      end
      if (!invert(dvs[dvs_cnt-1], n, linv)) begin
        last_st = ST_NOINV;
        return;
      end
      last_st = ST_OK;
      if (dvd_cnt < dvs_cnt) return;
      qlen = dvd_cnt - dvs_cnt + 1;
      for (int i = 0; i < qlen; i++) rem[i] = rem[i + dvs_cnt - 1];
      for (int k = qlen - 1; k >= 0; k--) begin
        r = rem[k];
        q = (r == 0) ? 0 : mulmod(r, linv, n);
        quo[k] = q;
        len = dvs_cnt - 1;
        if (len > k) len = k;
        for (int j = 1; j <= len && q != 0; j++) begin
          ri = k - j;
          y = mulmod(q, dvs[dvs_cnt-1-j], n);
          rem[ri] = (rem[ri] >= y) ? rem[ri] - y : rem[ri] + (n - y);
        end
      end
      while (qlen > 0 && quo[qlen-1] == 0) qlen--;
      quo_cnt = qlen;
    endfunction

    // Advance the predictor on one accepted request
    function void note_request(logic [OP_W-1:0] op, logic [COEFF_W-1:0] v,
                               logic last, logic [IDX_W-1:0] idx);
      answer_t a;
      a.coeff = '0;
      a.st = last_st;
      if (op == OP_LOAD_DIV) begin
        if (dvs_closed) begin dvs_cnt = 0; dvs_closed = 0; end
        if (dvs_cnt < LEN_MAX) begin dvs[dvs_cnt] = v % ring(); dvs_cnt++; end
        if (last) dvs_closed = 1;
      end else if (op == OP_LOAD_DVD) begin
        if (dvd_closed) begin dvd_cnt = 0; dvd_closed = 0; end
        if (dvd_cnt < LEN_MAX) begin rem[dvd_cnt] = v % ring(); dvd_cnt++; end
        if (last) begin
          dvd_closed = 1;
          divide();
          a.st = last_st;
        end
      end else if (op == OP_READ) begin
        if (idx < quo_cnt) begin
          a.coeff = quo[idx][COEFF_W-1:0];
          a.st = ST_OK;
        end else begin
          a.st = ST_RANGE;
        end
      end
      a.qlen = quo_cnt[LEN_W-1:0];
      pending.push_back(a);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(logic [COEFF_W-1:0] c, logic [LEN_W-1:0] l,
                               logic [ST_W-1:0] s);
      answer_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: coeff %0h len %0d st %0d", c, l, s);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (c !== e.coeff) begin
        $error("quotient_coeff expected %0h actual %0h", e.coeff, c); fails++;
      end
      if (l !== e.qlen) begin
        $error("quotient_length expected %0d actual %0d", e.qlen, l); fails++;
      end
      if (s !== e.st) begin
        $error("status expected %0d actual %0d", e.st, s); fails++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [COEFF_W-1:0] cfg_wr_data = '0;
  int                 cycles = 0;
  int                 gap_pct = 0;
  int                 stall_pct = 0;
  logic [COEFF_W-1:0] cur_mod = 32'd2;
  quotient_board      sb;

  pdm_item_if   item_ch ();
  pdm_result_if res_ch ();

  poly_div_mod_n u_top (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    item_ch.valid = 1'b0;
    item_ch.opcode = OP_LOAD_DIV;
    item_ch.coeff_value = '0;
    item_ch.last_item = 1'b0;
    item_ch.read_index = '0;
    res_ch.ready = 1'b0;
  end

  initial begin
    forever #6 clk = ~clk;
  end

  // Randomly stall the result side
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready)
        sb.note_request(item_ch.opcode, item_ch.coeff_value, item_ch.last_item,
                        item_ch.read_index);
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.quotient_coeff, res_ch.quotient_length, res_ch.status);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Issue one request, with a random gap in front
  task automatic send(logic [OP_W-1:0] op, logic [COEFF_W-1:0] v, logic last,
                      logic [IDX_W-1:0] idx);
    if ($urandom_range(99) < gap_pct) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_ch.opcode <= op;
    item_ch.coeff_value <= v;
    item_ch.last_item <= last;
    item_ch.read_index <= idx;
    item_ch.valid <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(logic [COEFF_W-1:0] m);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.modulus = m;
    cur_mod = m;
  endtask

  function automatic logic [COEFF_W-1:0] pick_coeff();
    logic [COEFF_W-1:0] n;
    n = (cur_mod < 2) ? 32'd2 : cur_mod;
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(n - 1, 0);
      2: return n - 1;
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(3, 0);
    endcase
  endfunction

  // Load a polynomial of the given length
  task automatic load_poly(logic [OP_W-1:0] op, int len, bit zero_top);
    for (int i = 0; i < len; i++)
      send(op, (zero_top && i == len - 1) ? '0 : pick_coeff(), i == len - 1,
           IDX_W'($urandom));
  endtask

  // Close both polynomials so the next phase starts clean
  task automatic close_phase();
    send(OP_LOAD_DIV, pick_coeff(), 1'b1, '0);
    send(OP_LOAD_DVD, pick_coeff(), 1'b1, '0);
  endtask

  task automatic random_phase(int count, bit with_long);
    int sent;
    int dl, vl;
    sent = 0;
    if (with_long) begin
      // overlong dividend against a short divisor, then overlong divisor
      // against a short dividend
      load_poly(OP_LOAD_DIV, 2, 0);
      load_poly(OP_LOAD_DVD, LEN_MAX + 3, 0);
      send(OP_READ, '0, 1'b0, 8'd255);
      send(OP_READ, '0, 1'b0, 8'd254);
      load_poly(OP_LOAD_DIV, LEN_MAX + 2, 0);
      load_poly(OP_LOAD_DVD, 3, 0);
      send(OP_READ, '0, 1'b0, 8'd0);
    end
    while (sent < count) begin
      if ($urandom_range(99) < 70) begin
        dl = $urandom_range(1, 5);
        vl = $urandom_range(1, 9);
        load_poly(OP_LOAD_DIV, dl, $urandom_range(9) == 0);
        load_poly(OP_LOAD_DVD, vl, 0);
        sent += dl + vl;
        repeat ($urandom_range(1, 4)) begin
          send(OP_READ, $urandom, 1'($urandom_range(1)),
               ($urandom_range(3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(9, 0)));
          sent++;
        end
      end else begin
        send(OP_W'($urandom_range(3)), $urandom, 1'($urandom_range(1)), IDX_W'($urandom));
        sent++;
      end
    end
    close_phase();
  endtask

  initial begin
    logic [COEFF_W-1:0] mods [8];
    sb = new();
    mods = '{32'd0, 32'hFFFF_FFFF, 32'd4294967291, 32'd1,
             32'd256, 32'd7, 32'd1000000007, 32'd3};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset modulus, empty divisor, reads, odd opcode
    send(OP_READ, '0, 1'b0, 8'd0);
    send(OP_LOAD_DVD, 32'd1, 1'b1, '0);
    send(OP_LOAD_DIV, 32'd1, 1'b1, '0);
    send(OP_LOAD_DVD, 32'd1, 1'b0, '0);
    send(OP_LOAD_DVD, 32'd0, 1'b0, '0);
    send(OP_LOAD_DVD, 32'hFFFF_FFFF, 1'b1, '0);
    send(OP_READ, '0, 1'b0, 8'd0);
    send(OP_READ, '0, 1'b0, 8'd2);
    send(OP_READ, '0, 1'b0, 8'd3);
    send(OP_READ, 32'hFFFF_FFFF, 1'b1, 8'd255);
    send(OP_SPARE, 32'hFFFF_FFFF, 1'b1, 8'd255);
    // zero leading coefficient
    send(OP_LOAD_DIV, 32'd1, 1'b0, '0);
    send(OP_LOAD_DIV, 32'd0, 1'b1, '0);
    send(OP_LOAD_DVD, 32'd5, 1'b1, '0);
    // dividend shorter than divisor
    send(OP_LOAD_DIV, 32'd1, 1'b0, '0);
    send(OP_LOAD_DIV, 32'd1, 1'b0, '0);
    send(OP_LOAD_DIV, 32'd1, 1'b1, '0);
    send(OP_LOAD_DVD, 32'd1, 1'b0, '0);
    send(OP_LOAD_DVD, 32'd1, 1'b1, '0);
    send(OP_READ, '0, 1'b0, 8'd0);
    close_phase();

    // Random phases over several moduli and idling patterns
    for (int p = 0; p < 8; p++) begin
      write_modulus(mods[p]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 62; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 62; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      random_phase(25, p == 2);
    end

    drain();
    stall_pct = 0;
    repeat (DRAIN) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
